// ===== rtl/core/brsr_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the bad sector remap table
package brsr_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int SECTOR_W = 32;
	localparam int COUNT_W = 6;
	localparam int SEQ_W = 64;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_FULL      = 3'd2,
		ST_CONFLICT  = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_ADD    = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] bad;
		logic [SECTOR_W-1:0] repl;
	} entry_t;

endpackage

// ===== rtl/core/brsr_if.sv =====
`timescale 1ns / 1ps
// request and response channel interfaces for the remap table
interface brsr_req_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [brsr_pkg::SECTOR_W-1:0] bad_in;
	logic [brsr_pkg::SECTOR_W-1:0] replacement_in;

	modport source (output valid, output cmd, output bad_in, output replacement_in,
		input ready);
	modport sink (input valid, input cmd, input bad_in, input replacement_in,
		output ready);
endinterface

interface brsr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    status;
	logic [brsr_pkg::SECTOR_W-1:0] replacement_out;
	logic [brsr_pkg::COUNT_W-1:0]  count_out;
	logic [brsr_pkg::SEQ_W-1:0]    sequence_out;

	modport source (output valid, output status, output replacement_out,
		output count_out, output sequence_out, input ready);
	modport sink (input valid, input status, input replacement_out,
		input count_out, input sequence_out, output ready);
endinterface

// ===== rtl/core/brsr_mem.sv =====
`timescale 1ns / 1ps
// entry memory: one write port, one read port with registered read data
module brsr_mem #(
	parameter int DEPTH = brsr_pkg::MAX_ENTRIES,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  brsr_pkg::entry_t  wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output brsr_pkg::entry_t  rdata
);

	brsr_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/bad_sector_remap_table.sv =====
`timescale 1ns / 1ps
// bad sector remap table: sequential scan over the entry memory
// throughput: one item at a time; the single-port read of the entry memory sets the
//   scan at one entry per cycle
// reset: entry count zero, sequence one, no response pending; memory contents are
//   never read at or above the entry count, so they need no clearing
module bad_sector_remap_table #(
	parameter int MAX_ENTRIES = brsr_pkg::MAX_ENTRIES
) (
	input  logic       clk,
	input  logic       arst_n,
	brsr_req_if.sink   req,
	brsr_rsp_if.source rsp
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	brsr_pkg::state_t state_q, state_d;

	// request held during the scan
	logic                          cmd_q;
	logic [brsr_pkg::SECTOR_W-1:0] bad_q;
	logic [brsr_pkg::SECTOR_W-1:0] repl_q;

	logic [CNT_W-1:0]              total_q;
	logic [brsr_pkg::SEQ_W-1:0]    seq_q;
	logic [CNT_W-1:0]              addr_q;
	logic                          rd_vld_s1;

	brsr_pkg::status_t             res_status_q, res_status_d;
	logic [brsr_pkg::SECTOR_W-1:0] res_repl_q, res_repl_d;
	logic                          res_load;

	logic                          rsp_vld_q;
	brsr_pkg::status_t             rsp_status_q;
	logic [brsr_pkg::SECTOR_W-1:0] rsp_repl_q;
	logic [brsr_pkg::COUNT_W-1:0]  rsp_count_q;
	logic [brsr_pkg::SEQ_W-1:0]    rsp_seq_q;

	brsr_pkg::entry_t              rdata;
	brsr_pkg::entry_t              wdata;
	logic                          issue;
	logic                          hit;
	logic                          mem_we;
	logic                          accept;
	logic                          out_free;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_vld_q || rsp.ready;
	assign issue    = (state_q == brsr_pkg::S_SCAN) && (addr_q < total_q);
	assign wdata    = '{bad: bad_q, repl: repl_q};

	always_comb begin
		if (cmd_q == brsr_pkg::CMD_ADD) begin
			hit = (rdata.bad == bad_q) || (rdata.repl == bad_q) ||
				(rdata.bad == repl_q) || (rdata.repl == repl_q);
		end else begin
			hit = (rdata.bad == bad_q);
		end
	end

	brsr_mem #(
		.DEPTH (MAX_ENTRIES),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (total_q[IDX_W-1:0]),
		.wdata (wdata),
		.re    (issue),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		state_d      = state_q;
		res_load     = 1'b0;
		res_status_d = brsr_pkg::ST_OK;
		res_repl_d   = '0;
		mem_we       = 1'b0;
		req.ready    = 1'b0;
		unique case (state_q)
			brsr_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.cmd == brsr_pkg::CMD_ADD) begin
						if (req.bad_in == '0 || req.replacement_in == '0 ||
							req.bad_in == req.replacement_in) begin
							res_load     = 1'b1;
							res_status_d = brsr_pkg::ST_INVALID;
							state_d      = brsr_pkg::S_DONE;
						end else if (total_q >= CNT_MAX) begin
							res_load     = 1'b1;
							res_status_d = brsr_pkg::ST_FULL;
							state_d      = brsr_pkg::S_DONE;
						end else begin
							state_d = brsr_pkg::S_SCAN;
						end
					end else if (req.bad_in == '0) begin
						res_load     = 1'b1;
						res_status_d = brsr_pkg::ST_NOT_FOUND;
						state_d      = brsr_pkg::S_DONE;
					end else begin
						state_d = brsr_pkg::S_SCAN;
					end
				end
			end
			brsr_pkg::S_SCAN: begin
				if (rd_vld_s1 && hit) begin
					res_load = 1'b1;
					state_d  = brsr_pkg::S_DONE;
					if (cmd_q == brsr_pkg::CMD_ADD) begin
						res_status_d = brsr_pkg::ST_CONFLICT;
					end else begin
						res_status_d = brsr_pkg::ST_OK;
						res_repl_d   = rdata.repl;
					end
				end else if (!issue && !rd_vld_s1) begin
					// scan ran out without a match
					res_load = 1'b1;
					state_d  = brsr_pkg::S_DONE;
					if (cmd_q == brsr_pkg::CMD_ADD) begin
						mem_we       = 1'b1;
						res_status_d = brsr_pkg::ST_OK;
					end else begin
						res_status_d = brsr_pkg::ST_NOT_FOUND;
					end
				end
			end
			brsr_pkg::S_DONE: begin
				if (out_free) begin
					state_d = brsr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = brsr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= brsr_pkg::S_IDLE;
			total_q   <= '0;
			seq_q     <= brsr_pkg::SEQ_W'(1);
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				total_q <= total_q + CNT_W'(1);
				seq_q   <= seq_q + brsr_pkg::SEQ_W'(1);
			end
			if (accept) begin
				addr_q <= '0;
			end else if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			rd_vld_s1 <= issue && (state_d == brsr_pkg::S_SCAN);
			if (state_q == brsr_pkg::S_DONE && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.cmd;
			bad_q  <= req.bad_in;
			repl_q <= req.replacement_in;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_repl_q   <= res_repl_d;
		end
		if (state_q == brsr_pkg::S_DONE && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_repl_q   <= res_repl_q;
			rsp_count_q  <= brsr_pkg::COUNT_W'(total_q);
			rsp_seq_q    <= seq_q;
		end
	end

	// count and sequence are captured with the response, the next item may add meanwhile
	assign rsp.valid           = rsp_vld_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.replacement_out = rsp_repl_q;
	assign rsp.count_out       = rsp_count_q;
	assign rsp.sequence_out    = rsp_seq_q;

endmodule
